// ----- rtl/core/mgps_pkg.sv -----
// Shared constants, widths and the CORDIC arctangent table for the pursuit steering block.
package mgps_pkg;

	localparam int TABLE_LEN = 24;
	localparam int IDX_W = 5;
	localparam int DIV_W = 21;
	localparam int DCNT_W = 5;
	localparam int ANGLE_LIMIT = 12868;
	localparam int SUM_MAX = 1048575;
	localparam int SUM_MIN = -1048576;
	localparam logic [15:0] WHEEL_BASE_RESET = 16'd11424;

	typedef logic signed [39:0] cordic_t;
	typedef logic signed [31:0] angle_acc_t;

	function automatic angle_acc_t atan_q30(input logic [IDX_W-1:0] idx);
		angle_acc_t v;
		case (idx)
			5'd0: v = 32'sd843314857;
			5'd1: v = 32'sd497837829;
			5'd2: v = 32'sd263043837;
			5'd3: v = 32'sd133525159;
			5'd4: v = 32'sd67021687;
			5'd5: v = 32'sd33543516;
			5'd6: v = 32'sd16775851;
			5'd7: v = 32'sd8388437;
			5'd8: v = 32'sd4194283;
			5'd9: v = 32'sd2097149;
			5'd10: v = 32'sd1048575;
			5'd11: v = 32'sd524288;
			5'd12: v = 32'sd262144;
			5'd13: v = 32'sd131072;
			5'd14: v = 32'sd65536;
			5'd15: v = 32'sd32768;
			5'd16: v = 32'sd16384;
			5'd17: v = 32'sd8192;
			5'd18: v = 32'sd4096;
			5'd19: v = 32'sd2048;
			5'd20: v = 32'sd1024;
			5'd21: v = 32'sd512;
			5'd22: v = 32'sd256;
			5'd23: v = 32'sd128;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/multi_goal_pursuit_steering_top.sv -----
// Top level of the multi-goal pure-pursuit steering block with its sequencer and shared units.
//
// Channel    Direction  Handshake                 Payload
// input      in         in_valid / in_ready       goal_x, goal_y, last_point
// result     out        out_valid / out_ready     avg_angle, point_count, overflowed
// config     in         wheel_base_we             wheel_base
//
// A kept point holds the input through the transfer, three multiplier passes, a load, one
// CORDIC rotation per cycle for CORDIC_STEPS rotations, rounding and accumulation; with a zero
// numerator or denominator the rotations and rounding are skipped. A dropped point takes only
// its transfer. A last point adds the divider setup, bit-serial restoring divider and output load.
// Reset clears the sum, the count, the drop flag and the wheelbase to 2.789 m.
// A result waits in the output register; the final load stalls only if that register is full.
module multi_goal_pursuit_steering_top #(
	parameter int MAX_POINTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wheel_base_we,
	input  logic [15:0]        wheel_base,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] goal_x,
	input  logic signed [15:0] goal_y,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] avg_angle,
	output logic [6:0]         point_count,
	output logic               overflowed
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
	localparam logic [mgps_pkg::IDX_W-1:0] ITER_LAST = mgps_pkg::IDX_W'(CORDIC_STEPS - 1);
	localparam logic [mgps_pkg::DCNT_W-1:0] DIV_LAST = mgps_pkg::DCNT_W'(mgps_pkg::DIV_W - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MX    = 4'd1;
	localparam logic [3:0] S_MY    = 4'd2;
	localparam logic [3:0] S_MW    = 4'd3;
	localparam logic [3:0] S_LOAD  = 4'd4;
	localparam logic [3:0] S_ITER  = 4'd5;
	localparam logic [3:0] S_ROUND = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_DSET  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]                       state_q;
	logic [15:0]                      wb_q;
	logic signed [20:0]               sum_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             drop_q;
	logic                             out_valid_q;
	logic [mgps_pkg::IDX_W-1:0]       iter_q;
	logic [mgps_pkg::DCNT_W-1:0]      dcnt_q;

	logic signed [15:0]               gx_q;
	logic signed [15:0]               gy_q;
	logic                             last_q;
	logic signed [33:0]               prod_q;
	logic [31:0]                      den_q;
	mgps_pkg::cordic_t                cx_q;
	mgps_pkg::cordic_t                cy_q;
	mgps_pkg::angle_acc_t             z_q;
	logic signed [14:0]               ang_q;
	logic [mgps_pkg::DIV_W-1:0]       dq_q;
	logic [CNT_W:0]                   rem_q;
	logic                             dsign_q;
	logic signed [14:0]               angle_out_q;
	logic [6:0]                       count_out_q;
	logic                             ovf_out_q;

	logic                             in_xfer;
	logic                             out_load;
	logic signed [16:0]               mul_a;
	logic signed [16:0]               mul_b;
	logic signed [33:0]               prod;
	mgps_pkg::cordic_t                dx;
	mgps_pkg::cordic_t                dy;
	mgps_pkg::angle_acc_t             atan_val;
	logic [32:0]                      zmag;
	logic [32:0]                      zrnd;
	logic [15:0]                      rmag;
	logic signed [14:0]               rlim;
	logic signed [14:0]               ang_round;
	logic signed [21:0]               sum_ext;
	logic signed [20:0]               sum_sat;
	logic [CNT_W:0]                   trial;
	logic                             trial_ge;
	logic [mgps_pkg::DIV_W:0]         avg_full;
	logic [CNT_W+6:0]                 cnt_ext;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (state_q)
			S_MX: begin
				mul_a = 17'(gx_q);
				mul_b = 17'(gx_q);
			end
			S_MY: begin
				mul_a = 17'(gy_q);
				mul_b = 17'(gy_q);
			end
			default: begin
				mul_a = $signed({1'b0, wb_q});
				mul_b = 17'(gy_q);
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign dx = cy_q >>> iter_q;
	assign dy = cx_q >>> iter_q;
	assign atan_val = mgps_pkg::atan_q30(iter_q);

	always_comb begin
		zmag = z_q[31] ? (33'd0 - {z_q[31], z_q}) : {1'b0, z_q};
		zrnd = zmag + 33'd65536;
		rmag = zrnd[32:17];
		rlim = (rmag > 16'(mgps_pkg::ANGLE_LIMIT)) ? 15'(mgps_pkg::ANGLE_LIMIT) : $signed(rmag[14:0]);
		ang_round = z_q[31] ? -rlim : rlim;
	end

	always_comb begin
		sum_ext = 22'(sum_q) + 22'(ang_q);
		if (sum_ext > 22'(mgps_pkg::SUM_MAX)) begin
			sum_sat = 21'(mgps_pkg::SUM_MAX);
		end else if (sum_ext < 22'(mgps_pkg::SUM_MIN)) begin
			sum_sat = 21'(mgps_pkg::SUM_MIN);
		end else begin
			sum_sat = sum_ext[20:0];
		end
	end

	assign trial = {rem_q[CNT_W-1:0], dq_q[mgps_pkg::DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, cnt_q});
	assign avg_full = dsign_q ? ((mgps_pkg::DIV_W+1)'(0) - {1'b0, dq_q}) : {1'b0, dq_q};
	assign cnt_ext = {7'd0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wb_q <= mgps_pkg::WHEEL_BASE_RESET;
			sum_q <= '0;
			cnt_q <= '0;
			drop_q <= 1'b0;
			out_valid_q <= 1'b0;
			iter_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (wheel_base_we) begin
				wb_q <= wheel_base;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (cnt_q == CNT_FULL) begin
							drop_q <= 1'b1;
							if (last_point) begin
								state_q <= S_DSET;
							end
						end else begin
							state_q <= S_MX;
						end
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_MW;
				S_MW: state_q <= S_LOAD;
				S_LOAD: begin
					iter_q <= '0;
					if (den_q == '0 || prod_q == '0) begin
						state_q <= S_ACC;
					end else begin
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_LAST) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: state_q <= S_ACC;
				S_ACC: begin
					sum_q <= sum_sat;
					cnt_q <= cnt_q + 1'b1;
					state_q <= last_q ? S_DSET : S_IDLE;
				end
				S_DSET: begin
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIV_LAST) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						sum_q <= '0;
						cnt_q <= '0;
						drop_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			gx_q <= goal_x;
			gy_q <= goal_y;
			last_q <= last_point;
		end
		if (state_q == S_MX || state_q == S_MY || state_q == S_MW) begin
			prod_q <= prod;
		end
		if (state_q == S_MY) begin
			den_q <= prod_q[31:0];
		end
		if (state_q == S_MW) begin
			den_q <= den_q + prod_q[31:0];
		end
		if (state_q == S_LOAD) begin
			cx_q <= {4'd0, den_q, 4'd0};
			cy_q <= {{5{prod_q[33]}}, prod_q, 1'b0};
			z_q <= '0;
			ang_q <= '0;
		end
		if (state_q == S_ITER) begin
			if (!cy_q[39]) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q <= z_q + atan_val;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q <= z_q - atan_val;
			end
		end
		if (state_q == S_ROUND) begin
			ang_q <= ang_round;
		end
		if (state_q == S_DSET) begin
			dq_q <= sum_q[20] ? (21'd0 - sum_q) : sum_q;
			dsign_q <= sum_q[20];
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			if (trial_ge) begin
				rem_q <= trial - {1'b0, cnt_q};
			end else begin
				rem_q <= trial;
			end
			dq_q <= {dq_q[mgps_pkg::DIV_W-2:0], trial_ge};
		end
		if (out_load) begin
			angle_out_q <= (cnt_q == '0) ? 15'sd0 : $signed(avg_full[14:0]);
			count_out_q <= cnt_ext[6:0];
			ovf_out_q <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign avg_angle = angle_out_q;
	assign point_count = count_out_q;
	assign overflowed = ovf_out_q;

endmodule

// ----- rtl/core/mgps_checker.sv -----
// Port-level checker for the pursuit steering block and its bind to the top level.
module mgps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] avg_angle,
	input logic [6:0]         point_count,
	input logic               overflowed
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result was withdrawn before its transfer.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(avg_angle) && $stable(point_count)
			&& $stable(overflowed))
		else $error("Result payload changed while stalled.");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(avg_angle) <= 15'sd12868)
			&& ($signed(avg_angle) >= -15'sd12868))
		else $error("Average steering angle is outside the clamp range.");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("A result appeared while the block was taking points.");

endmodule

bind multi_goal_pursuit_steering_top mgps_checker u_mgps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.avg_angle(avg_angle),
	.point_count(point_count),
	.overflowed(overflowed)
);

// ----- tb/sv/tb_multi_goal_pursuit_steering_top.sv -----
// Self-checking testbench for the multi-goal pure-pursuit steering block.
`timescale 1ns / 1ps

typedef struct {
	logic signed [14:0] angle;
	logic [6:0]         count;
	logic               dropped;
} steer_result_t;

class steering_average_tracker #(int CAPACITY = 64, int ITERS = 16);
	logic [15:0]   wheel_base_q;
	int            angle_sum;
	int            points_seen;
	bit            drop_flag;
	longint        atan_lut[24];
	steer_result_t pending_averages[$];
	int            points_taken;
	int            averages_checked;
	int            dropped_sets;
	int            mismatches;

	function new();
		atan_lut = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048575, 524288,
			262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128};
		wheel_base_q = mgps_pkg::WHEEL_BASE_RESET;
		angle_sum = 0;
		points_seen = 0;
		drop_flag = 0;
		points_taken = 0;
		averages_checked = 0;
		dropped_sets = 0;
		mismatches = 0;
	endfunction

	function void set_wheel_base(logic [15:0] value);
		wheel_base_q = value;
	endfunction

	function int steer_angle_q13(longint gx, longint gy);
		longint wb;
		longint den;
		longint num;
		longint cx;
		longint cy;
		longint z;
		longint dx;
		longint dy;
		longint r;
		wb = wheel_base_q;
		den = (gx * gx + gy * gy) * 16;
		num = 2 * wb * gy;
		if (den == 0 || num == 0)
			return 0;
		cx = den;
		cy = num;
		z = 0;
		for (int i = 0; i < ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + atan_lut[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - atan_lut[i];
			end
		end
		if (z >= 0)
			r = (z + 65536) >>> 17;
		else
			r = -((-z + 65536) >>> 17);
		if (r > mgps_pkg::ANGLE_LIMIT)
			r = mgps_pkg::ANGLE_LIMIT;
		if (r < -mgps_pkg::ANGLE_LIMIT)
			r = -mgps_pkg::ANGLE_LIMIT;
		return int'(r);
	endfunction

	function void take_point(logic signed [15:0] gx, logic signed [15:0] gy, logic ends_set);
		longint        s;
		int            avg;
		steer_result_t res;
		points_taken++;
		if (points_seen < CAPACITY) begin
			s = longint'(angle_sum) + steer_angle_q13(gx, gy);
			if (s > mgps_pkg::SUM_MAX)
				s = mgps_pkg::SUM_MAX;
			if (s < mgps_pkg::SUM_MIN)
				s = mgps_pkg::SUM_MIN;
			angle_sum = int'(s);
			points_seen++;
		end else begin
			drop_flag = 1;
		end
		if (!ends_set)
			return;
		avg = 0;
		if (points_seen != 0)
			avg = angle_sum / points_seen;
		res.angle = 15'(avg);
		res.count = 7'(points_seen);
		res.dropped = drop_flag;
		if (drop_flag)
			dropped_sets++;
		pending_averages.push_back(res);
		angle_sum = 0;
		points_seen = 0;
		drop_flag = 0;
	endfunction

	function void check_average(logic signed [14:0] angle, logic [6:0] count, logic dropped);
		steer_result_t want;
		if (pending_averages.size() == 0) begin
			$error("Steering result with no pending set: angle %0d, count %0d", angle, count);
			mismatches++;
			return;
		end
		want = pending_averages.pop_front();
		averages_checked++;
		if (angle !== want.angle) begin
			$error("avg_angle: expected %0d, got %0d", want.angle, angle);
			mismatches++;
		end
		if (count !== want.count) begin
			$error("point_count: expected %0d, got %0d", want.count, count);
			mismatches++;
		end
		if (dropped !== want.dropped) begin
			$error("overflowed: expected %0d, got %0d", want.dropped, dropped);
			mismatches++;
		end
	endfunction
endclass

module tb_multi_goal_pursuit_steering_top;
	localparam int MAX_PTS = 64;
	localparam int ITERS = 16;

	logic               clk;
	logic               arst_n;
	logic               wheel_base_we;
	logic [15:0]        wheel_base;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] goal_x;
	logic signed [15:0] goal_y;
	logic               last_point;
	logic               out_valid;
	logic               out_ready;
	logic signed [14:0] avg_angle;
	logic [6:0]         point_count;
	logic               overflowed;

	int send_idle;
	int recv_idle;
	steering_average_tracker #(MAX_PTS, ITERS) tracker;

	multi_goal_pursuit_steering_top #(
		.MAX_POINTS(MAX_PTS),
		.CORDIC_STEPS(ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wheel_base_we(wheel_base_we),
		.wheel_base(wheel_base),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.goal_x(goal_x),
		.goal_y(goal_y),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_angle(avg_angle),
		.point_count(point_count),
		.overflowed(overflowed)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_average(avg_angle, point_count, overflowed);
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle = 28;
				recv_idle = 80;
			end
			1: begin
				send_idle = 80;
				recv_idle = 28;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic ends_set);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		goal_x <= x;
		goal_y <= y;
		last_point <= ends_set;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_point(x, y, ends_set);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_averages.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_wheel_base(input logic [15:0] value);
		@(negedge clk);
		wheel_base_we <= 1'b1;
		wheel_base <= value;
		@(negedge clk);
		wheel_base_we <= 1'b0;
		tracker.set_wheel_base(value);
	endtask

	function automatic logic signed [15:0] pick_coord();
		int v;
		case ($urandom_range(6))
			0, 1, 2, 3: v = $urandom;
			4: v = int'($urandom_range(512)) - 256;
			5: v = 0;
			default: begin
				case ($urandom_range(3))
					0: v = 32767;
					1: v = -32768;
					2: v = 1;
					default: v = -1;
				endcase
			end
		endcase
		return 16'(v);
	endfunction

	function automatic int pick_set_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(8, 1);
		if (r < 85)
			return $urandom_range(30, 9);
		if (r < 93)
			return $urandom_range(MAX_PTS, MAX_PTS - 4);
		return $urandom_range(MAX_PTS + 8, MAX_PTS + 1);
	endfunction

	initial begin
		logic [15:0] wb_plan[6];
		int          sent;
		int          n;
		tracker = new();
		arst_n = 1'b0;
		wheel_base_we = 1'b0;
		wheel_base = '0;
		in_valid = 1'b0;
		goal_x = '0;
		goal_y = '0;
		last_point = 1'b0;
		set_idling(0);
		wb_plan[0] = mgps_pkg::WHEEL_BASE_RESET;
		wb_plan[1] = 16'hFFFF;
		wb_plan[2] = 16'h0000;
		wb_plan[3] = 16'h0001;
		wb_plan[4] = 16'($urandom);
		wb_plan[5] = 16'($urandom);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd32767, 16'sd0, 1'b1);
		send_point(16'sd0, 16'sd32767, 1'b1);
		send_point(16'sd0, -16'sd32768, 1'b1);
		send_point(16'sd0, 16'sd1, 1'b1);
		send_point(16'sd0, -16'sd1, 1'b1);
		send_point(-16'sd32768, -16'sd32768, 1'b1);
		send_point(16'sd32767, 16'sd32767, 1'b1);
		send_point(-16'sd32768, 16'sd32767, 1'b1);
		send_point(16'sd32767, -16'sd32768, 1'b1);
		send_point(16'sd1, 16'sd1, 1'b1);
		send_point(-16'sd1, -16'sd1, 1'b1);
		send_point(16'sd256, 16'sd256, 1'b1);
		send_point(-16'sd256, 16'sd100, 1'b1);
		send_point(16'sd1280, 16'sd64, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1280, -16'sd200, 1'b1);
		send_point(16'sd512, -16'sd300, 1'b0);
		send_point(-16'sd512, 16'sd300, 1'b1);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase != 0) begin
				drain_results();
				load_wheel_base(wb_plan[phase]);
			end
			set_idling(phase / 2);
			sent = 0;
			while (sent < 100) begin
				n = pick_set_len();
				for (int k = 0; k < n; k++)
					send_point(pick_coord(), pick_coord(), k == n - 1);
				sent += n;
			end
		end
		drain_results();

		$display("Checked %0d averaged steering results from %0d goal points; %0d sets dropped points.",
			tracker.averages_checked, tracker.points_taken, tracker.dropped_sets);
		$display("Wheelbase ran from zero to full scale under three handshake idling patterns.");
		if (tracker.mismatches == 0 && tracker.pending_averages.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
